// ===== hw/rtl/chi_square_uniformity_test_macros.svh =====
// ----------------------------------------------------------------------------
// Chi-square uniformity test assertion macros
// Shorthand for the clocked implications used by the port checker.
// ----------------------------------------------------------------------------
`ifndef CHI_SQUARE_UNIFORMITY_TEST_MACROS_SVH
`define CHI_SQUARE_UNIFORMITY_TEST_MACROS_SVH

// Same-cycle implication, aborted while rst is high.
`define CSQ_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("chi-square checker: same-cycle property failed");

// Next-cycle implication, aborted while rst is high.
`define CSQ_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("chi-square checker: next-cycle property failed");

`endif

// ===== hw/rtl/csq_pkg.sv =====
// ----------------------------------------------------------------------------
// Chi-square uniformity test package
// Shared widths, defaults and constants.
// ----------------------------------------------------------------------------
package csq_pkg;

   localparam int SAMPLE_W        = 32;
   localparam int STAT_W          = 32;
   localparam int FRAC_BITS       = 16;
   localparam int NUM_BINS_DEF    = 20;
   localparam int MAX_SAMPLES_DEF = 1048576;

   localparam logic [STAT_W-1:0] THRESHOLD_RESET = 32'd1975517;
   localparam logic [STAT_W-1:0] CHI2_SAT        = 32'hFFFF_FFFF;

endpackage

// ===== hw/rtl/csq_ifs.sv =====
// ----------------------------------------------------------------------------
// Chi-square uniformity test channel interfaces
// Valid/ready channels for samples, results and the threshold register.
// ----------------------------------------------------------------------------
interface csq_req_if;
   import csq_pkg::*;
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] sample;
   logic                last;
   modport source (output valid, output sample, output last, input ready);
   modport sink   (input valid, input sample, input last, output ready);
endinterface

interface csq_rsp_if;
   import csq_pkg::*;
   logic              valid;
   logic              ready;
   logic [STAT_W-1:0] chi2_q16;
   logic              passed;
   logic              overflow;
   modport source (output valid, output chi2_q16, output passed, output overflow,
                   input ready);
   modport sink   (input valid, input chi2_q16, input passed, input overflow,
                   output ready);
endinterface

interface csq_csr_if;
   import csq_pkg::*;
   logic              valid;
   logic              ready;
   logic [STAT_W-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/csq_div.sv =====
// ----------------------------------------------------------------------------
// Chi-square restoring divider
// Unsigned division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module csq_div #(
   parameter int DW = 63,
   parameter int VW = 21
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] dividend,
   input  logic [VW-1:0] divisor,
   output logic          done,
   output logic [DW-1:0] quotient
);
   localparam int SW = $clog2(DW);

   logic [VW-1:0] rem_ff,  rem_in;
   logic [DW-1:0] dq_ff,   dq_in;
   logic [SW-1:0] cnt_ff,  cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [VW:0]   trial;
   logic [VW:0]   diff;
   logic          fits;

   assign trial = {rem_ff, dq_ff[DW-1]};
   assign diff  = trial - {1'b0, divisor};
   assign fits  = trial >= {1'b0, divisor};

   always_comb begin
      rem_in  = rem_ff;
      dq_in   = dq_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         dq_in   = dividend;
         cnt_in  = SW'(DW - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // shift in one quotient bit, keep the partial remainder below the divisor
         rem_in = fits ? diff[VW-1:0] : trial[VW-1:0];
         dq_in  = {dq_ff[DW-2:0], fits};
         cnt_in = cnt_ff - SW'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dq_ff  <= dq_in;
   end

   assign done     = done_ff;
   assign quotient = dq_ff;

endmodule

// ===== hw/rtl/chi_square_uniformity_test.sv =====
// ----------------------------------------------------------------------------
// Chi-square uniformity test
// Histograms uniform samples into NUM_BINS bins and, on the last sample of a
// data set, reports the chi-square statistic in Q16.16 with pass and
// saturation flags.
// ----------------------------------------------------------------------------
//
//  channel   dir  fields                         handshake
//  --------  ---  -----------------------------  ----------------------------
//  req_bus   in   sample[31:0], last             valid & ready
//  rsp_bus   out  chi2_q16[31:0], passed,        valid & ready, output reg
//                 overflow
//  csr_bus   in   data[31:0] (pass threshold)    valid & ready, always ready
//
//  A sample passes through accept, bin index through the shared constant
//  multiplier with the histogram RAM read, then the counter write-back.
//  A last sample adds the evaluation: per bin, the sum of squares steps
//  through RAM read, scale by NUM_BINS, square and accumulate; the divider
//  then forms NUM_BINS*sum << 16 over N, one quotient bit per cycle for DW
//  bits, raises its done flag, and the result register is loaded.
//  Reset clears the histogram through per-bin valid bits.
//  A stalled result holds in the output register; a further sample is taken
//  meanwhile, and only the next result load waits for it to drain.
//
module chi_square_uniformity_test #(
   parameter int NUM_BINS    = csq_pkg::NUM_BINS_DEF,
   parameter int MAX_SAMPLES = csq_pkg::MAX_SAMPLES_DEF
) (
   input  logic      clock,
   input  logic      reset,
   csq_req_if.sink   req_bus,
   csq_rsp_if.source rsp_bus,
   csq_csr_if.sink   csr_bus
);
   import csq_pkg::*;

   // counter, bin index and product widths
   localparam int CW     = $clog2(MAX_SAMPLES + 1);
   localparam int BW     = $clog2(NUM_BINS);
   localparam int NBW    = $clog2(NUM_BINS + 1);
   localparam int MW     = SAMPLE_W + NBW;
   localparam int NCW    = CW + NBW;
   localparam int PW_RAW = NCW + CW;
   localparam int PW     = (PW_RAW > FRAC_BITS + 1) ? PW_RAW : FRAC_BITS + 1;
   localparam int DW     = PW + FRAC_BITS;

   // sequencer codes
   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_BIN  = 4'd1;
   localparam logic [3:0] ST_INC  = 4'd2;
   localparam logic [3:0] ST_RD   = 4'd3;
   localparam logic [3:0] ST_MUL1 = 4'd4;
   localparam logic [3:0] ST_MUL2 = 4'd5;
   localparam logic [3:0] ST_ACC  = 4'd6;
   localparam logic [3:0] ST_DIV  = 4'd7;
   localparam logic [3:0] ST_FIN  = 4'd8;

   logic [3:0]          state_ff, state_in;
   logic [SAMPLE_W-1:0] sample_ff, sample_in;
   logic                last_ff, last_in;
   logic [BW-1:0]       idx_ff, idx_in;
   logic [NUM_BINS-1:0] valid_ff, valid_in;
   logic [CW-1:0]       total_ff, total_in;
   logic                sat_ff, sat_in;
   logic [BW-1:0]       bin_ff, bin_in;
   logic [CW-1:0]       c_ff, c_in;
   logic [NCW-1:0]      nc_ff, nc_in;
   logic [PW-1:0]       prod_ff, prod_in;
   logic [PW-1:0]       acc_ff, acc_in;
   logic [STAT_W-1:0]   thr_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0]   chi2_ff, chi2_in;
   logic                passed_ff, passed_in;
   logic                ovf_ff, ovf_in;

   // histogram RAM
   logic [CW-1:0]       bin_mem [NUM_BINS];
   logic [CW-1:0]       rd_data_ff;
   logic                rd_valid_ff;
   logic [BW-1:0]       rd_addr;
   logic                mem_we;

   logic [SAMPLE_W-1:0] mul_op;
   logic [MW-1:0]       mul_prod;
   logic [NBW-1:0]      idx_raw;
   logic [BW-1:0]       idx_clamp;
   logic [CW-1:0]       cnt_rd;
   logic [PW-1:0]       sq_prod;
   logic [PW-1:0]       acc_sum;
   logic                div_start;
   logic                div_done;
   logic [DW-1:0]       div_quo;
   logic [PW-1:0]       q_whole;
   logic [PW-1:0]       n_ext;
   logic [PW-1:0]       excess;
   logic [STAT_W-1:0]   chi2_calc;
   logic                rsp_free;

   // shared multiply by NUM_BINS: bin index for a sample, scaled count in evaluation
   assign mul_op    = (state_ff == ST_BIN) ? sample_ff : SAMPLE_W'(cnt_rd);
   assign mul_prod  = MW'(mul_op) * MW'(NUM_BINS);
   assign idx_raw   = mul_prod[MW-1:SAMPLE_W];
   assign idx_clamp = (idx_raw >= NBW'(NUM_BINS)) ? BW'(NUM_BINS - 1) : idx_raw[BW-1:0];

   // a bin never written since the last clear reads as zero
   assign cnt_rd  = rd_valid_ff ? rd_data_ff : '0;
   assign sq_prod = PW'(nc_ff) * PW'(c_ff);
   assign acc_sum = acc_ff + prod_ff;
   assign rd_addr = (state_ff == ST_BIN) ? idx_clamp : bin_ff;

   // floor(P*2^16/N) = q*2^16 + floor(r*2^16/N); subtract N from the whole part
   assign q_whole = div_quo[DW-1:FRAC_BITS];
   assign n_ext   = PW'(total_ff);
   assign excess  = q_whole - n_ext;

   always_comb begin
      priority if (q_whole < n_ext) begin
         chi2_calc = '0;
      end else if (excess[PW-1:FRAC_BITS] != '0) begin
         chi2_calc = CHI2_SAT;
      end else begin
         chi2_calc = {excess[FRAC_BITS-1:0], div_quo[FRAC_BITS-1:0]};
      end
   end

   assign rsp_free = !rsp_valid_ff || rsp_bus.ready;

   always_comb begin
      state_in     = state_ff;
      sample_in    = sample_ff;
      last_in      = last_ff;
      idx_in       = idx_ff;
      valid_in     = valid_ff;
      total_in     = total_ff;
      sat_in       = sat_ff;
      bin_in       = bin_ff;
      c_in         = c_ff;
      nc_in        = nc_ff;
      prod_in      = prod_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      chi2_in      = chi2_ff;
      passed_in    = passed_ff;
      ovf_in       = ovf_ff;
      mem_we       = 1'b0;
      div_start    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            // prime the evaluation walk while waiting
            bin_in = '0;
            acc_in = '0;
            if (req_bus.valid) begin
               sample_in = req_bus.sample;
               last_in   = req_bus.last;
               state_in  = ST_BIN;
            end
         end
         ST_BIN: begin
            idx_in = idx_clamp;
            if (total_ff == CW'(MAX_SAMPLES)) begin
               // drop the sample, flag saturation
               sat_in   = 1'b1;
               state_in = last_ff ? ST_RD : ST_IDLE;
            end else begin
               state_in = ST_INC;
            end
         end
         ST_INC: begin
            mem_we           = 1'b1;
            valid_in[idx_ff] = 1'b1;
            total_in         = total_ff + CW'(1);
            state_in         = last_ff ? ST_RD : ST_IDLE;
         end
         ST_RD: begin
            state_in = ST_MUL1;
         end
         ST_MUL1: begin
            c_in     = cnt_rd;
            nc_in    = mul_prod[NCW-1:0];
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            prod_in  = sq_prod;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            acc_in = acc_sum;
            if (bin_ff == BW'(NUM_BINS - 1)) begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end else begin
               bin_in   = bin_ff + BW'(1);
               state_in = ST_RD;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            // hold until the output register drains, then clear the data set
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               chi2_in      = chi2_calc;
               passed_in    = chi2_calc < thr_ff;
               ovf_in       = sat_ff;
               valid_in     = '0;
               total_in     = '0;
               sat_in       = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         total_ff     <= '0;
         sat_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         thr_ff       <= THRESHOLD_RESET;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         total_ff     <= total_in;
         sat_ff       <= sat_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_bus.valid) begin
            thr_ff <= csr_bus.data;
         end
      end
   end

   always_ff @(posedge clock) begin
      sample_ff <= sample_in;
      last_ff   <= last_in;
      idx_ff    <= idx_in;
      bin_ff    <= bin_in;
      c_ff      <= c_in;
      nc_ff     <= nc_in;
      prod_ff   <= prod_in;
      acc_ff    <= acc_in;
      chi2_ff   <= chi2_in;
      passed_ff <= passed_in;
      ovf_ff    <= ovf_in;
   end

   // histogram RAM: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         bin_mem[idx_ff] <= cnt_rd + CW'(1);
      end
      rd_data_ff  <= bin_mem[rd_addr];
      rd_valid_ff <= valid_ff[rd_addr];
   end

   csq_div #(
      .DW (DW),
      .VW (CW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({acc_sum, FRAC_BITS'(0)}),
      .divisor  (total_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign req_bus.ready    = (state_ff == ST_IDLE);
   assign csr_bus.ready    = 1'b1;
   assign rsp_bus.valid    = rsp_valid_ff;
   assign rsp_bus.chi2_q16 = chi2_ff;
   assign rsp_bus.passed   = passed_ff;
   assign rsp_bus.overflow = ovf_ff;

endmodule

// ===== hw/rtl/csq_check.sv =====
// ----------------------------------------------------------------------------
// Chi-square uniformity test port checker
// Watches the top-level channels and is bound to every instance.
// ----------------------------------------------------------------------------
`include "chi_square_uniformity_test_macros.svh"

module csq_check (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic [csq_pkg::STAT_W-1:0] rsp_chi2_q16,
   input logic                      rsp_passed,
   input logic                      rsp_overflow
);
   import csq_pkg::*;

   logic [STAT_W+1:0] rsp_payload;

   assign rsp_payload = {rsp_chi2_q16, rsp_passed, rsp_overflow};

   // a stalled result keeps its place
   `CSQ_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   // and its payload
   `CSQ_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_payload))
   // a request keeps the block busy for at least the binning cycle
   `CSQ_ASSERT_NEXT(a_req_busy, clock, reset, req_valid && req_ready, !req_ready)
   // a saturated statistic can never be below any threshold
   `CSQ_ASSERT_SAME(a_sat_fails, clock, reset, rsp_valid && rsp_passed, rsp_chi2_q16 != CHI2_SAT)
   // reset empties the output register
   `CSQ_ASSERT_NEXT(a_rst_empty, clock, 1'b0, reset, !rsp_valid)

endmodule

bind chi_square_uniformity_test csq_check u_csq_check (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_bus.valid),
   .req_ready    (req_bus.ready),
   .rsp_valid    (rsp_bus.valid),
   .rsp_ready    (rsp_bus.ready),
   .rsp_chi2_q16 (rsp_bus.chi2_q16),
   .rsp_passed   (rsp_bus.passed),
   .rsp_overflow (rsp_bus.overflow)
);

// ===== test/chi_square_uniformity_test_test.sv =====
// ----------------------------------------------------------------------------
// Chi-square uniformity test testbench
// Streams sample requests into the histogram block and scores every reported
// statistic against a local histogram predictor or a typed table result: a
// directed table first, then randomized data sets under several pass thresholds,
// with one long receiver hold-off and, at the end, a closing stretch without idling.
// ----------------------------------------------------------------------------
module chi_square_uniformity_test_test;
   timeunit 1ns;
   timeprecision 1ps;

   import csq_pkg::*;

   // Allowance for an evaluation: the per-bin sum of squares plus the quotient bits.
   localparam int unsigned EVAL_CYCLES   = 4 * NUM_BINS_DEF + 66;
   localparam int unsigned SETTLE_CYCLES = EVAL_CYCLES + 34;
   localparam int unsigned HOLD_CYCLES   = 1500;
   localparam int unsigned CYCLE_LIMIT   = 4_000_000;
   // Width of one bin in sample units, rounded up so that k * BIN_STEP lands in bin k.
   localparam logic [SAMPLE_W-1:0] BIN_STEP = 32'd214748365;

   typedef struct packed {
      logic [STAT_W-1:0] chi2;
      logic              passed;
      logic              overflow;
   } verdict_type;

   typedef enum logic [0:0] {
      ROW_SAMPLES,
      ROW_THRESHOLD
   } row_kind_type;

   // A samples row sends 'repeats' samples first, first + stride, ...; only the
   // final one carries 'last'. A threshold row writes 'first' to the register.
   typedef struct packed {
      row_kind_type        kind;
      logic [SAMPLE_W-1:0] first;
      logic [SAMPLE_W-1:0] stride;
      logic [31:0]         repeats;
      logic                last;
      logic                typed;
      logic [STAT_W-1:0]   chi2;
      logic                passed;
      logic                overflow;
   } stim_row_type;

   localparam int unsigned NUM_ROWS = 20;
   localparam stim_row_type DIRECTED_ROWS [NUM_ROWS] = '{
      // single samples at both ends of the range, reset threshold
      '{ROW_SAMPLES,   32'h0000_0000, 32'h0, 32'd1,    1'b1, 1'b1, 32'h0013_0000, 1'b1, 1'b0},
      '{ROW_SAMPLES,   32'hFFFF_FFFF, 32'h0, 32'd1,    1'b1, 1'b1, 32'h0013_0000, 1'b1, 1'b0},
      // two neighbors across the half-way bin boundary
      '{ROW_SAMPLES,   32'h8000_0000, 32'h0, 32'd1,    1'b0, 1'b0, 32'h0,         1'b0, 1'b0},
      '{ROW_SAMPLES,   32'h7FFF_FFFF, 32'h0, 32'd1,    1'b1, 1'b0, 32'h0,         1'b0, 1'b0},
      // one sample per bin: a perfectly flat histogram
      '{ROW_SAMPLES,   32'h0000_0000, BIN_STEP, 32'd20, 1'b1, 1'b1, 32'h0,        1'b1, 1'b0},
      '{ROW_SAMPLES,   32'h0000_1000, 32'h0, 32'd3,    1'b0, 1'b0, 32'h0,         1'b0, 1'b0},
      '{ROW_SAMPLES,   32'h4000_0000, 32'h0, 32'd1,    1'b1, 1'b0, 32'h0,         1'b0, 1'b0},
      // everything in one bin: the statistic reaches (NUM_BINS - 1) * N
      '{ROW_SAMPLES,   32'h1234_5678, 32'h0, 32'd40,   1'b1, 1'b1, 32'h02F8_0000, 1'b0, 1'b0},
      // threshold equal to the statistic fails, one above passes
      '{ROW_THRESHOLD, 32'h0013_0000, 32'h0, 32'd0,    1'b0, 1'b0, 32'h0,         1'b0, 1'b0},
      '{ROW_SAMPLES,   32'h0000_0000, 32'h0, 32'd1,    1'b1, 1'b1, 32'h0013_0000, 1'b0, 1'b0},
      '{ROW_THRESHOLD, 32'h0013_0001, 32'h0, 32'd0,    1'b0, 1'b0, 32'h0,         1'b0, 1'b0},
      '{ROW_SAMPLES,   32'h5555_5555, 32'h0, 32'd1,    1'b1, 1'b1, 32'h0013_0000, 1'b1, 1'b0},
      // zero threshold: even a flat histogram fails
      '{ROW_THRESHOLD, 32'h0000_0000, 32'h0, 32'd0,    1'b0, 1'b0, 32'h0,         1'b0, 1'b0},
      '{ROW_SAMPLES,   32'h0000_0000, BIN_STEP, 32'd20, 1'b1, 1'b1, 32'h0,        1'b0, 1'b0},
      // full-scale threshold: even a one-bin histogram passes
      '{ROW_THRESHOLD, 32'hFFFF_FFFF, 32'h0, 32'd0,    1'b0, 1'b0, 32'h0,         1'b0, 1'b0},
      '{ROW_SAMPLES,   32'hABCD_0123, 32'h0, 32'd40,   1'b1, 1'b1, 32'h02F8_0000, 1'b1, 1'b0},
      '{ROW_SAMPLES,   32'h0000_0000, 32'h0ABC_DEF1, 32'd17, 1'b1, 1'b0, 32'h0,   1'b0, 1'b0},
      // back to the reset value, with a remainder in the division
      '{ROW_THRESHOLD, THRESHOLD_RESET, 32'h0, 32'd0,  1'b0, 1'b0, 32'h0,         1'b0, 1'b0},
      '{ROW_SAMPLES,   32'h8000_0000, 32'h0, 32'd2,    1'b0, 1'b0, 32'h0,         1'b0, 1'b0},
      '{ROW_SAMPLES,   32'hFFFF_FFFF, 32'h0, 32'd1,    1'b1, 1'b0, 32'h0,         1'b0, 1'b0}
   };

   logic clock = 1'b0;
   logic reset;

   csq_req_if req_if ();
   csq_rsp_if rsp_if ();
   csq_csr_if csr_if ();

   chi_square_uniformity_test u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if),
      .csr_bus (csr_if)
   );

   always #4 clock = ~clock;

   // Histogram predictor state: a private copy of the bins, total, saturation
   // flag and pass threshold.
   logic [20:0]       bin_tally [NUM_BINS_DEF];
   logic [20:0]       tally_total;
   logic              tally_clipped;
   logic [STAT_W-1:0] threshold_q16;

   verdict_type expected_verdicts [$];
   int unsigned mismatches       = 0;
   int unsigned results_seen     = 0;
   int unsigned samples_sent     = 0;
   int unsigned sets_closed      = 0;
   int unsigned threshold_writes = 0;
   int unsigned hold_cycles_done = 0;
   int unsigned cycles_run       = 0;

   // Pacing controls shared between stimulus and the receiver.
   logic        idle_on      = 1'b1;
   logic        sender_quiet = 1'b0;
   logic        pressure_go  = 1'b0;
   logic        rsp_hold     = 1'b0;
   int unsigned stall_left   = 0;
   int unsigned calm_left    = 0;

   function automatic void clear_histogram();
      foreach (bin_tally[i]) bin_tally[i] = '0;
      tally_total   = '0;
      tally_clipped = 1'b0;
   endfunction

   // Append one expectation behind those already pending.
   function automatic void queue_verdict(input verdict_type verdict);
      expected_verdicts.insert(expected_verdicts.size(), verdict);
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("[%0t] result %0d: %s got 0x%0h, want 0x%0h", $realtime, results_seen, what,
               got, want);
      mismatches++;
   endtask

   // Offer one sample request, wait for its acceptance, then fold it into the
   // histogram predictor. On a last sample, score the data set and clear.
   task automatic feed_sample(input logic [SAMPLE_W-1:0] sample, input logic is_last,
                              output verdict_type verdict);
      int unsigned gap;
      int unsigned idx;
      logic [63:0] prod;
      logic [63:0] n;
      logic [63:0] sumsq;
      logic [63:0] p;
      logic [63:0] q;
      logic [63:0] r;
      logic [63:0] chi;
      if (idle_on && !sender_quiet && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 19);
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid  <= 1'b1;
      req_if.sample <= sample;
      req_if.last   <= is_last;
      @(posedge clock);
      while (req_if.ready !== 1'b1) @(posedge clock);
      samples_sent++;

      // Drop the sample once the count has saturated; else bin it.
      if (tally_total >= MAX_SAMPLES_DEF) begin
         tally_clipped = 1'b1;
      end else begin
         prod = 64'(sample) * 64'(NUM_BINS_DEF);
         idx  = int'(prod >> 32);
         if (idx >= NUM_BINS_DEF) idx = NUM_BINS_DEF - 1;
         bin_tally[idx] = bin_tally[idx] + 1'b1;
         tally_total    = tally_total + 1'b1;
      end

      verdict = '0;
      if (is_last) begin
         // chi2 = NUM_BINS * sum(c^2) / N - N, integer part and 16-bit fraction
         n     = 64'(tally_total);
         sumsq = '0;
         foreach (bin_tally[i]) sumsq += 64'(bin_tally[i]) * 64'(bin_tally[i]);
         if (n == 0) begin
            chi = '0;
         end else begin
            p = 64'(NUM_BINS_DEF) * sumsq;
            q = p / n;
            r = p % n;
            if (q < n) chi = '0;
            else if (q - n > 64'hFFFF) chi = 64'(CHI2_SAT);
            else chi = ((q - n) << FRAC_BITS) + ((r << FRAC_BITS) / n);
         end
         verdict.chi2     = chi[STAT_W-1:0];
         verdict.passed   = (n != 0) && (chi[STAT_W-1:0] < threshold_q16);
         verdict.overflow = tally_clipped;
         clear_histogram();
         sets_closed++;
      end
   endtask

   // Drop the request valid, wait for every pending result, then let any
   // sample still in flight finish.
   task automatic settle_block();
      req_if.valid <= 1'b0;
      while (expected_verdicts.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_threshold(input logic [STAT_W-1:0] value);
      settle_block();
      csr_if.valid <= 1'b1;
      csr_if.data  <= value;
      @(posedge clock);
      while (csr_if.ready !== 1'b1) @(posedge clock);
      csr_if.valid  <= 1'b0;
      threshold_q16 = value;
      threshold_writes++;
   endtask

   // One random data set: mostly short, sometimes long; the samples are fully
   // random, bunched into neighboring bins, or sitting on bin edges.
   task automatic random_data_set(input int unsigned max_len);
      int unsigned len;
      int unsigned style;
      int unsigned pick;
      int unsigned base_bin;
      int unsigned edge_bin;
      logic [SAMPLE_W-1:0] sample;
      verdict_type verdict;
      len = $urandom_range(1, max_len);
      if (max_len > 8 && $urandom_range(0, 9) < 6) len = $urandom_range(1, 8);
      if (max_len > 8 && $urandom_range(0, 19) == 0) len = $urandom_range(41, 200);
      style        = $urandom_range(0, 3);
      base_bin     = $urandom_range(0, NUM_BINS_DEF - 2);
      sender_quiet = ($urandom_range(0, 4) == 0);
      for (int unsigned k = 0; k < len; k++) begin
         pick = (style == 3) ? $urandom_range(0, 2) : style;
         case (pick)
            0: begin
               sample = $urandom;
            end
            1: begin
               sample = (base_bin + $urandom_range(0, 1)) * BIN_STEP
                        + $urandom_range(0, 214748360);
            end
            default: begin
               edge_bin = $urandom_range(1, NUM_BINS_DEF - 1);
               sample   = edge_bin * BIN_STEP - $urandom_range(0, 1);
               if ($urandom_range(0, 7) == 0) sample = $urandom_range(0, 1) ? '0 : '1;
            end
         endcase
         feed_sample(sample, k == len - 1, verdict);
      end
      queue_verdict(verdict);
   endtask

   // Compare every accepted result with the oldest pending expectation.
   always @(posedge clock) begin : result_check
      verdict_type want;
      if (reset === 1'b0 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         results_seen++;
         if (expected_verdicts.size() == 0) begin
            report_mismatch("result with nothing pending, chi2", 64'(rsp_if.chi2_q16),
                            64'(0));
         end else begin
            want = expected_verdicts.pop_front();
            if (rsp_if.chi2_q16 !== want.chi2)
               report_mismatch("chi2_q16", 64'(rsp_if.chi2_q16), 64'(want.chi2));
            if (rsp_if.passed !== want.passed)
               report_mismatch("passed", 64'(rsp_if.passed), 64'(want.passed));
            if (rsp_if.overflow !== want.overflow)
               report_mismatch("overflow", 64'(rsp_if.overflow), 64'(want.overflow));
         end
      end
   end

   // Receiver pacing: random stall bursts, calm stretches with none, and the
   // long hold-off whenever it is asserted.
   always @(posedge clock) begin : result_pacing
      if (rsp_hold) begin
         rsp_if.ready <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left   <= stall_left - 1;
         rsp_if.ready <= 1'b0;
      end else if (calm_left != 0) begin
         calm_left    <= calm_left - 1;
         rsp_if.ready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 11) == 0) begin
         stall_left   <= $urandom_range(0, 18);
         rsp_if.ready <= 1'b0;
      end else begin
         if (idle_on && $urandom_range(0, 39) == 0) calm_left <= $urandom_range(50, 300);
         rsp_if.ready <= 1'b1;
      end
   end

   // Hold off the receiver once, long enough that the block backs up into
   // its request side while samples keep coming.
   initial begin : receiver_hold
      wait (pressure_go === 1'b1);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) begin
         @(posedge clock);
         hold_cycles_done++;
      end
      rsp_hold <= 1'b0;
   end

   // Abort on a hung handshake.
   initial begin : watchdog
      while (cycles_run < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles_run++;
      end
      $display("[%0t] timeout after %0d cycles, %0d results still pending", $realtime,
               cycles_run, expected_verdicts.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin : stimulus
      stim_row_type        row;
      verdict_type         verdict;
      verdict_type         typed_verdict;
      logic [31:0]         k;
      logic [STAT_W-1:0]   next_threshold;
      int unsigned         phase_samples;
      int unsigned         phase_sets;

      // Drive every input to a known value while reset is held, then release it.
      reset         = 1'b1;
      req_if.valid  = 1'b0;
      req_if.sample = '0;
      req_if.last   = 1'b0;
      rsp_if.ready  = 1'b0;
      csr_if.valid  = 1'b0;
      csr_if.data   = '0;
      clear_histogram();
      threshold_q16 = THRESHOLD_RESET;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed table. Rows with a typed result check against it; the rest
      // take the predictor's verdict.
      foreach (DIRECTED_ROWS[i]) begin
         row = DIRECTED_ROWS[i];
         if (row.kind == ROW_THRESHOLD) begin
            write_threshold(row.first);
         end else begin
            for (k = 0; k < row.repeats; k++) begin
               feed_sample(row.first + row.stride * k, row.last && (k == row.repeats - 1),
                           verdict);
               if (row.last && (k == row.repeats - 1)) begin
                  typed_verdict = '{chi2: row.chi2, passed: row.passed,
                                    overflow: row.overflow};
                  queue_verdict(row.typed ? typed_verdict : verdict);
               end
            end
         end
      end

      // Random data sets, one threshold per phase. In the third phase hold
      // off the receiver and keep offering short data sets into it.
      for (int unsigned phase = 0; phase < 5; phase++) begin
         case (phase)
            0:       next_threshold = $urandom_range(0, 40 << FRAC_BITS);
            1:       next_threshold = CHI2_SAT;
            2:       next_threshold = $urandom_range(10 << FRAC_BITS, 30 << FRAC_BITS);
            3:       next_threshold = '0;
            default: next_threshold = $urandom;
         endcase
         write_threshold(next_threshold);
         if (phase == 2) begin
            pressure_go <= 1'b1;
            repeat (20) random_data_set(3);
         end
         phase_samples = samples_sent;
         phase_sets    = sets_closed;
         while (samples_sent - phase_samples < 70 || sets_closed - phase_sets < 4)
            random_data_set(40);
      end

      // Closing stretch without idling: restore the reset threshold and run
      // a few sets back to back.
      idle_on <= 1'b0;
      write_threshold(THRESHOLD_RESET);
      repeat (3) random_data_set(40);

      settle_block();
      $display("covered %0d samples in %0d data sets, %0d results compared, %0d threshold writes",
               samples_sent, sets_closed, results_seen, threshold_writes);
      $display("receiver held off for %0d cycles while sample requests kept arriving",
               hold_cycles_done);
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
